/* design/utf8_validate_whitespace_collapse_assert.svh */
// Assertion macros for the blocks of the UTF-8 whitespace collapser.
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef UTF8_VALIDATE_WHITESPACE_COLLAPSE_ASSERT_SVH
`define UTF8_VALIDATE_WHITESPACE_COLLAPSE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UVWC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8vwc: same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define UVWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8vwc: next-cycle implication failed");

// The expression must never be true.
`define UVWC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("utf8vwc: forbidden condition seen");

`endif

/* design/utf8vwc_pkg.sv */
package utf8vwc_pkg;

  localparam logic [20:0] MaxCode      = 21'h10ffff;
  localparam logic [20:0] SurrogateLo  = 21'h00d800;
  localparam logic [20:0] SurrogateHi  = 21'h00dfff;
  localparam logic [20:0] MinClass1    = 21'h000080;
  localparam logic [20:0] MinClass2    = 21'h000800;
  localparam logic [20:0] MinClass3    = 21'h010000;

  localparam logic [7:0] Lead2Lo = 8'hc2;
  localparam logic [7:0] Lead2Hi = 8'hdf;
  localparam logic [7:0] Lead3Lo = 8'he0;
  localparam logic [7:0] Lead3Hi = 8'hef;
  localparam logic [7:0] Lead4Lo = 8'hf0;
  localparam logic [7:0] Lead4Hi = 8'hf4;

  localparam logic [1:0] Class1 = 2'd1;
  localparam logic [1:0] Class2 = 2'd2;
  localparam logic [1:0] Class3 = 2'd3;

  // One result word as it leaves the block.
  typedef struct packed {
    logic            space_before;
    logic [2:0]      byte_count;
    logic [3:0][7:0] bytes;
    logic            text_end;
    logic            invalid_text;
  } result_t;

  // Unicode White_Space property, plus the separators 0x1c to 0x1f.
  function automatic logic is_space(input logic [20:0] c);
    logic hit;
    hit = c inside {[21'h9:21'hd], [21'h1c:21'h20], 21'h85, 21'ha0, 21'h1680,
                    [21'h2000:21'h200a], 21'h2028, 21'h2029, 21'h202f,
                    21'h205f, 21'h3000};
    return hit;
  endfunction

endpackage

/* design/utf8vwc_core.sv */
module utf8vwc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           text_byte_i,
  input  logic                 final_byte_i,
  output logic                 res_valid_o,
  output utf8vwc_pkg::result_t res_o
);
  import utf8vwc_pkg::*;

  logic [20:0] code_q, code_d;
  logic [1:0]  btc_q, btc_d;
  logic [1:0]  minc_q, minc_d;
  logic [7:0]  held_q [4];
  logic [7:0]  held_d [4];
  logic [2:0]  hcnt_q, hcnt_d;
  logic        seen_q, seen_d;
  logic        space_q, space_d;
  logic        error_q, error_d;

  logic        done;
  logic        emit;
  logic        space;
  logic        err;
  logic        emit_ok;
  logic [20:0] minimum;

  always_comb begin
    code_d  = code_q;
    btc_d   = btc_q;
    minc_d  = minc_q;
    held_d  = held_q;
    hcnt_d  = hcnt_q;
    seen_d  = seen_q;
    space_d = space_q;
    err     = error_q;
    done    = 1'b0;
    emit    = 1'b0;
    space   = 1'b0;
    minimum = '0;

    if (!error_q) begin
      if (btc_q == 2'd0) begin
        hcnt_d = 3'd0;
        if (text_byte_i[7] == 1'b0) begin
          code_d    = {13'd0, text_byte_i};
          minc_d    = 2'd0;
          held_d[0] = text_byte_i;
          hcnt_d    = 3'd1;
          done      = 1'b1;
        end else if (text_byte_i inside {[Lead2Lo:Lead2Hi]}) begin
          code_d    = {16'd0, text_byte_i[4:0]};
          btc_d     = 2'd1;
          minc_d    = Class1;
          held_d[0] = text_byte_i;
          hcnt_d    = 3'd1;
        end else if (text_byte_i inside {[Lead3Lo:Lead3Hi]}) begin
          code_d    = {17'd0, text_byte_i[3:0]};
          btc_d     = 2'd2;
          minc_d    = Class2;
          held_d[0] = text_byte_i;
          hcnt_d    = 3'd1;
        end else if (text_byte_i inside {[Lead4Lo:Lead4Hi]}) begin
          code_d    = {18'd0, text_byte_i[2:0]};
          btc_d     = 2'd3;
          minc_d    = Class3;
          held_d[0] = text_byte_i;
          hcnt_d    = 3'd1;
        end else begin
          err = 1'b1;
        end
      end else if (text_byte_i[7:6] != 2'b10) begin
        // A non-continuation byte inside a sequence is an error, not a new lead.
        err   = 1'b1;
        btc_d = 2'd0;
      end else begin
        code_d               = {code_q[14:0], text_byte_i[5:0]};
        held_d[hcnt_q[1:0]]  = text_byte_i;
        if (hcnt_q < 3'd4) begin
          hcnt_d = hcnt_q + 3'd1;
        end
        btc_d = btc_q - 2'd1;
        done  = (btc_q == 2'd1);
      end

      if (done) begin
        case (minc_d)
          Class1:  minimum = MinClass1;
          Class2:  minimum = MinClass2;
          Class3:  minimum = MinClass3;
          default: minimum = '0;
        endcase
        if (code_d < minimum || code_d > MaxCode ||
            (code_d >= SurrogateLo && code_d <= SurrogateHi)) begin
          err = 1'b1;
        end else if (is_space(code_d)) begin
          if (seen_q) begin
            space_d = 1'b1;
          end
        end else begin
          emit    = 1'b1;
          space   = space_q;
          space_d = 1'b0;
          seen_d  = 1'b1;
        end
      end

      if (final_byte_i && btc_d != 2'd0) begin
        err = 1'b1;
      end
    end

    error_d = err;
    emit_ok = emit && !err;

    res_valid_o        = accept_i && (emit || final_byte_i);
    res_o.space_before = emit_ok && space;
    res_o.byte_count   = emit_ok ? hcnt_d : 3'd0;
    for (int i = 0; i < 4; i++) begin
      res_o.bytes[i] = (emit_ok && 3'(i) < hcnt_d) ? held_d[i] : 8'd0;
    end
    res_o.text_end     = final_byte_i;
    res_o.invalid_text = final_byte_i && err;

    // The closing byte returns every control register to its reset value.
    if (final_byte_i) begin
      code_d  = '0;
      btc_d   = '0;
      minc_d  = '0;
      hcnt_d  = '0;
      seen_d  = 1'b0;
      space_d = 1'b0;
      error_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= '0;
      btc_q   <= '0;
      minc_q  <= '0;
      hcnt_q  <= '0;
      seen_q  <= 1'b0;
      space_q <= 1'b0;
      error_q <= 1'b0;
    end else if (accept_i) begin
      code_q  <= code_d;
      btc_q   <= btc_d;
      minc_q  <= minc_d;
      hcnt_q  <= hcnt_d;
      seen_q  <= seen_d;
      space_q <= space_d;
      error_q <= error_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

/* design/utf8vwc_outbuf.sv */
`include "utf8_validate_whitespace_collapse_assert.svh"

module utf8vwc_outbuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  utf8vwc_pkg::result_t push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output utf8vwc_pkg::result_t out_data_o
);
  import utf8vwc_pkg::*;

  result_t main_q;
  result_t skid_q;
  logic    main_valid_q;
  logic    skid_valid_q;
  logic    pop;

  assign pop         = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

  // The skid word is only ever filled behind a waiting output word.
  `UVWC_ASSERT_IMPL(a_skid_behind_main, skid_valid_q, main_valid_q)
  // No word may arrive while the skid stage is occupied.
  `UVWC_ASSERT_NEVER(a_no_push_when_full, push_i && skid_valid_q)
  // Draining the skid word keeps the output side presenting a word.
  `UVWC_ASSERT_NEXT(a_skid_refills_main, pop && skid_valid_q, main_valid_q && !skid_valid_q)

endmodule

/* design/utf8_validate_whitespace_collapse.sv */
// Channel  | Direction | Handshake              | Word
// ---------+-----------+------------------------+-------------------------------------------
// input    | in        | in_valid_i / in_stall_o | text_byte_i, final_byte_i
// output   | out       | out_valid_o / out_stall_i | space_before_o, byte_count_o,
//          |           |                        | out_byte0_o..out_byte3_o, text_end_o,
//          |           |                        | invalid_text_o
//
// One byte is accepted per clock while in_stall_o is low; decode, checks and whitespace
// tracking finish in the cycle of acceptance; the result word goes into the output stage.
// A two-word output stage (output register plus skid register) sets the rate: input
// stalls only while both words are held under an output stall.
// rst_ni clears the decoder's control registers and empties the output stage; no clearing pass.
module utf8_validate_whitespace_collapse (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       final_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       space_before_o,
  output logic [2:0] byte_count_o,
  output logic [7:0] out_byte0_o,
  output logic [7:0] out_byte1_o,
  output logic [7:0] out_byte2_o,
  output logic [7:0] out_byte3_o,
  output logic       text_end_o,
  output logic       invalid_text_o
);
  import utf8vwc_pkg::*;

  logic    accept;
  logic    res_valid;
  logic    full;
  result_t res;
  result_t out_word;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  utf8vwc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  utf8vwc_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_word)
  );

  assign space_before_o = out_word.space_before;
  assign byte_count_o   = out_word.byte_count;
  assign out_byte0_o    = out_word.bytes[0];
  assign out_byte1_o    = out_word.bytes[1];
  assign out_byte2_o    = out_word.bytes[2];
  assign out_byte3_o    = out_word.bytes[3];
  assign text_end_o     = out_word.text_end;
  assign invalid_text_o = out_word.invalid_text;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import utf8vwc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } text_item_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       space_before_o;
  logic [2:0] byte_count_o;
  logic [7:0] out_byte0_o;
  logic [7:0] out_byte1_o;
  logic [7:0] out_byte2_o;
  logic [7:0] out_byte3_o;
  logic       text_end_o;
  logic       invalid_text_o;

  utf8_validate_whitespace_collapse u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .final_byte_i   (final_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .space_before_o (space_before_o),
    .byte_count_o   (byte_count_o),
    .out_byte0_o    (out_byte0_o),
    .out_byte1_o    (out_byte1_o),
    .out_byte2_o    (out_byte2_o),
    .out_byte3_o    (out_byte3_o),
    .text_end_o     (text_end_o),
    .invalid_text_o (invalid_text_o)
  );

  text_item_t  text_in_q[$];
  logic [7:0]  text_buf[$];
  result_t     expected_words[$];
  int          total_items = 0;
  int          items_accepted = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle = 36;
  int          recv_idle = 78;

  // Decoder shadow state.
  logic [20:0] code_acc = '0;
  logic [1:0]  cont_left = '0;
  logic [1:0]  len_class = '0;
  logic [7:0]  seq_bytes[4] = '{default: 8'h00};
  logic [2:0]  seq_len = '0;
  logic        content_seen = 1'b0;
  logic        gap_pending = 1'b0;
  logic        bad_text = 1'b0;

  logic [20:0] blank_codes[29] = '{
    21'h9, 21'ha, 21'hb, 21'hc, 21'hd, 21'h1c, 21'h1d, 21'h1e, 21'h1f, 21'h20,
    21'h85, 21'ha0, 21'h1680, 21'h2000, 21'h2001, 21'h2002, 21'h2003, 21'h2004,
    21'h2005, 21'h2006, 21'h2007, 21'h2008, 21'h2009, 21'h200a, 21'h2028,
    21'h2029, 21'h202f, 21'h205f, 21'h3000
  };

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic is_blank(input logic [20:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 29; i++) begin
      if (blank_codes[i] == c) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic hold_byte(input logic [7:0] b);
    seq_bytes[seq_len[1:0]] = b;
    if (seq_len < 3'd4) seq_len = seq_len + 3'd1;
  endtask

  // Updates the shadow decoder with one accepted word and queues the word
  // the block should give out for it, if any.
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    result_t     word;
    logic        done;
    logic        emit;
    logic        gap;
    logic [20:0] lowest;
    done = 1'b0;
    emit = 1'b0;
    gap = 1'b0;
    if (!bad_text) begin
      if (cont_left == 2'd0) begin
        seq_len = '0;
        if (b < 8'h80) begin
          code_acc = {13'd0, b};
          len_class = 2'd0;
          hold_byte(b);
          done = 1'b1;
        end else if (b >= Lead2Lo && b <= Lead2Hi) begin
          code_acc = {16'd0, b[4:0]};
          cont_left = 2'd1;
          len_class = Class1;
          hold_byte(b);
        end else if (b >= Lead3Lo && b <= Lead3Hi) begin
          code_acc = {17'd0, b[3:0]};
          cont_left = 2'd2;
          len_class = Class2;
          hold_byte(b);
        end else if (b >= Lead4Lo && b <= Lead4Hi) begin
          code_acc = {18'd0, b[2:0]};
          cont_left = 2'd3;
          len_class = Class3;
          hold_byte(b);
        end else begin
          bad_text = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        // A non-continuation byte inside a sequence is never a new lead.
        bad_text = 1'b1;
        cont_left = 2'd0;
      end else begin
        code_acc = {code_acc[14:0], b[5:0]};
        hold_byte(b);
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) done = 1'b1;
      end

      if (done) begin
        case (len_class)
          Class1: lowest = MinClass1;
          Class2: lowest = MinClass2;
          Class3: lowest = MinClass3;
          default: lowest = '0;
        endcase
        if (code_acc < lowest || code_acc > MaxCode ||
            (code_acc >= SurrogateLo && code_acc <= SurrogateHi)) begin
          bad_text = 1'b1;
        end else if (is_blank(code_acc)) begin
          if (content_seen) gap_pending = 1'b1;
        end else begin
          emit = 1'b1;
          gap = gap_pending;
          gap_pending = 1'b0;
          content_seen = 1'b1;
        end
      end
      if (fin && cont_left != 2'd0) bad_text = 1'b1;
    end

    if (emit || fin) begin
      if (bad_text) emit = 1'b0;
      word = '0;
      word.space_before = emit && gap;
      word.byte_count = emit ? seq_len : 3'd0;
      for (int i = 0; i < 4; i++) begin
        word.bytes[i] = (emit && i < seq_len) ? seq_bytes[i] : 8'h00;
      end
      word.text_end = fin;
      word.invalid_text = fin && bad_text;
      expected_words = {expected_words, word};
    end

    if (fin) begin
      code_acc = '0;
      cont_left = '0;
      len_class = '0;
      seq_bytes = '{default: 8'h00};
      seq_len = '0;
      content_seen = 1'b0;
      gap_pending = 1'b0;
      bad_text = 1'b0;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  task automatic append_byte(input logic [7:0] b);
    text_buf = {text_buf, b};
  endtask

  // Encodes a code point with the given length, overlong or not.
  task automatic put_code(input logic [20:0] cp, input int len);
    case (len)
      1: append_byte(cp[7:0]);
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic int code_len(input logic [20:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  function automatic logic [20:0] random_code();
    int          pick;
    logic [20:0] cp;
    pick = $urandom_range(99);
    if (pick < 30) cp = blank_codes[$urandom_range(28)];
    else if (pick < 55) cp = 21'($urandom_range(8'h7f));
    else if (pick < 70) cp = 21'($urandom_range(21'h7ff, 21'h80));
    else if (pick < 85) begin
      cp = 21'($urandom_range(21'hffff, 21'h800));
      if (cp >= SurrogateLo && cp <= SurrogateHi) cp = cp ^ 21'h4000;
    end else cp = 21'($urandom_range(MaxCode, MinClass3));
    return cp;
  endfunction

  task automatic flush_text();
    text_item_t item;
    while (text_buf.size() != 0) begin
      item.value = text_buf.pop_front();
      item.last = (text_buf.size() == 0);
      text_in_q = {text_in_q, item};
    end
  endtask

  // Stimulus and end of run.
  initial begin
    int          n_codes;
    int          kind;
    int          len;
    logic [20:0] cp;

    // Leading, inner and trailing whitespace of one, two and three bytes, plus extremes.
    text_buf = '{8'h20, 8'h41, 8'h09, 8'hc2, 8'ha0, 8'he3, 8'h80, 8'h80,
                 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h0a, 8'h7f, 8'h20};
    flush_text();
    // Overlong three-byte form.
    text_buf = '{8'he0, 8'h80, 8'h80};
    flush_text();
    // Surrogate.
    text_buf = '{8'hed, 8'ha0, 8'h80};
    flush_text();
    // Above the largest code point.
    text_buf = '{8'hf4, 8'h90, 8'h80, 8'h80};
    flush_text();
    // Content, then a missing continuation byte.
    text_buf = '{8'h41, 8'hc3, 8'h41};
    flush_text();
    // Text that ends inside a sequence.
    text_buf = '{8'he2, 8'h82};
    flush_text();
    // Zero byte, then a bad lead byte.
    text_buf = '{8'h00, 8'hff};
    flush_text();

    while (text_in_q.size() < 1030) begin
      n_codes = $urandom_range(16, 1);
      for (int k = 0; k < n_codes; k++) begin
        kind = $urandom_range(99);
        if (kind < 6) begin
          append_byte(8'($urandom_range(255)));
        end else if (kind < 9) begin
          cp = random_code();
          len = code_len(cp);
          put_code(cp, len);
          if (len > 1) begin
            for (int d = $urandom_range(len - 1, 1); d > 0; d--) void'(text_buf.pop_back());
          end
        end else if (kind < 10) begin
          put_code(21'($urandom_range(21'h7ff)), 3);
        end else if (kind < 11) begin
          put_code(21'($urandom_range(SurrogateHi, SurrogateLo)), 3);
        end else if (kind < 12) begin
          put_code(21'($urandom_range(21'h13ffff, 21'h110000)), 4);
        end else begin
          cp = random_code();
          put_code(cp, code_len(cp));
        end
      end
      flush_text();
    end
    total_items = text_in_q.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_accepted < total_items) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[utf8_validate_whitespace_collapse] OK");
    end else begin
      $display("[utf8_validate_whitespace_collapse] ERROR");
    end
    $finish;
  end

  // Driver: a word stays on the port until it is taken.
  always @(posedge clk_i) begin
    text_item_t item;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(text_byte_i, final_byte_i);
        items_accepted++;
        case (items_accepted * 3 / total_items)
          0: begin
            send_idle = 36;
            recv_idle = 78;
          end
          1: begin
            send_idle = 78;
            recv_idle = 36;
          end
          default: begin
            send_idle = 0;
            recv_idle = 0;
          end
        endcase
      end
      if (!in_valid_i || !in_stall_o) begin
        if (text_in_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          item = text_in_q.pop_front();
          in_valid_i <= 1'b1;
          text_byte_i <= item.value;
          final_byte_i <= item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and output stall.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
      if (out_valid_o && !out_stall_i) begin
        got.space_before = space_before_o;
        got.byte_count = byte_count_o;
        got.bytes = {out_byte3_o, out_byte2_o, out_byte1_o, out_byte0_o};
        got.text_end = text_end_o;
        got.invalid_text = invalid_text_o;
        if (expected_words.size() == 0) begin
          flag_mismatch($sformatf("unexpected word %h", got));
        end else begin
          want = expected_words.pop_front();
          if (got.space_before !== want.space_before ||
              got.byte_count !== want.byte_count ||
              got.bytes !== want.bytes ||
              got.text_end !== want.text_end ||
              got.invalid_text !== want.invalid_text) begin
            flag_mismatch($sformatf(
                {"expected sp=%b cnt=%0d bytes=%h end=%b inv=%b, ",
                 "got sp=%b cnt=%0d bytes=%h end=%b inv=%b"},
                want.space_before, want.byte_count, want.bytes, want.text_end,
                want.invalid_text, got.space_before, got.byte_count, got.bytes,
                got.text_end, got.invalid_text));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[utf8_validate_whitespace_collapse] ERROR");
      $finish;
    end
  end

endmodule

/* utf8_validate_whitespace_collapse.f */
+incdir+design
design/utf8vwc_pkg.sv
design/utf8vwc_core.sv
design/utf8vwc_outbuf.sv
design/utf8_validate_whitespace_collapse.sv
verif/testbench.sv
